// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

   // Default grid geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // Stream payload widths
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 32;
   localparam int CURSOR_W   = 11;

   // Character and attribute constants
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] ATTR_RESET   = 8'd15;

   // Command codes carried in req_tuser[1:0]
   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_code_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture the request transaction
      logic decode;      // resolve target cell and error
      logic exec;        // write cell, move cursor, arm a sweep
      logic sweep_step;  // one cell of a scroll, clear or reset pass
      logic finish;      // load the response register
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sweep_req;   // valid during exec: a grid pass must follow
      logic sweep_last;  // sweep is on its last cell
   } dp_status_type;

endpackage

// ===== rtl/core/tcw_ctrl.sv =====
module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output tcw_pkg::ctl_cmd_type   ctl_cmd,
   input  tcw_pkg::dp_status_type dp_status
);
   import tcw_pkg::*;

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_DECODE = 6'b000100,
      ST_EXEC   = 6'b001000,
      ST_SWEEP  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Response register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      unique case (state_ff)
         ST_INIT: begin
            ctl_cmd.sweep_step = 1'b1;
            if (dp_status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl_cmd.load = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ctl_cmd.decode = 1'b1;
            state_in       = ST_EXEC;
         end
         ST_EXEC: begin
            ctl_cmd.exec = 1'b1;
            state_in     = dp_status.sweep_req ? ST_SWEEP : ST_FINISH;
         end
         ST_SWEEP: begin
            ctl_cmd.sweep_step = 1'b1;
            if (dp_status.sweep_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               ctl_cmd.finish = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Response valid: set on finish, cleared when the transaction is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl_cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/tcw_datapath.sv =====
module tcw_datapath #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tcw_pkg::ctl_cmd_type            ctl_cmd,
   output tcw_pkg::dp_status_type          dp_status,
   input  logic [tcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [tcw_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            csr_wr_en,
   input  logic [7:0]                      csr_wr_data,
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int BASE  = (ROWS - 1) * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CLW   = $clog2(COLUMNS);

   typedef enum logic [1:0] {
      MODE_ZERO   = 2'd0,
      MODE_SCROLL = 2'd1,
      MODE_BLANK  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_COPY  = 2'd1,
      SRC_BLANK = 2'd2
   } src_type;

   // Captured request
   cmd_code_type cmd_ff;
   logic [7:0]   ch_ff;
   logic         use_pos_ff;
   logic [4:0]   row_ff;
   logic [6:0]   col_ff;
   logic [7:0]   attr_ff;

   // Decoded target
   logic [RW-1:0]  tgt_row_ff, tgt_row_in;
   logic [CLW-1:0] tgt_col_ff, tgt_col_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic           err_ff, err_in;
   logic           given_sel, in_grid;

   // Cursor and default attribute
   logic [RW-1:0]  cur_row_ff, cur_row_in;
   logic [CLW-1:0] cur_col_ff, cur_col_in;
   logic [7:0]     def_attr_ff;

   // Execute
   logic           put_ok, is_nl, wrap, last_row, overflow, put_we;
   logic [CLW:0]   col_inc;
   logic [7:0]     attr_eff;
   logic           scrolled_ff, scrolled_in;

   // Sweep engine
   logic [AW-1:0]  scan_ff, scan_in;
   mode_type       mode_ff, mode_in;
   logic           copy_now;
   logic           wr_pend_ff;
   logic [AW-1:0]  wr_addr_ff;
   src_type        wr_src_ff, wr_src_in;

   // Cell memory: attribute in the high byte, character in the low byte
   logic [15:0]    mem [CELLS];
   logic [15:0]    rd_data_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr, rd_addr;
   logic [15:0]    mem_wdata;

   // Response register
   logic [CURSOR_W-1:0] out_cursor_ff;
   logic                out_scrolled_ff;
   logic [7:0]          out_char_ff, out_attr_ff;
   logic                out_err_ff;

   // Capture request transaction
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         cmd_ff     <= cmd_code_type'(req_tuser[1:0]);
         use_pos_ff <= req_tuser[2];
         ch_ff      <= req_tdata[7:0];
         row_ff     <= req_tdata[12:8];
         col_ff     <= req_tdata[19:13];
         attr_ff    <= req_tdata[27:20];
      end
   end

   // Decode: pick given position or cursor, flag positions off the grid
   always_comb begin
      given_sel  = (cmd_ff == CMD_READ) || use_pos_ff;
      in_grid    = (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS);
      err_in     = given_sel && !in_grid && ((cmd_ff == CMD_PUT) || (cmd_ff == CMD_READ));
      tgt_row_in = given_sel ? RW'(row_ff) : cur_row_ff;
      tgt_col_in = given_sel ? CLW'(col_ff) : cur_col_ff;
      addr_in    = AW'(32'(tgt_row_in) * COLUMNS + 32'(tgt_col_in));
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.decode) begin
         tgt_row_ff <= tgt_row_in;
         tgt_col_ff <= tgt_col_in;
         addr_ff    <= addr_in;
         err_ff     <= err_in;
      end
   end

   // Execute: cell write, cursor step, wrap and scroll detection
   always_comb begin
      put_ok   = (cmd_ff == CMD_PUT) && !err_ff;
      is_nl    = (ch_ff == NEWLINE_CODE);
      col_inc  = {1'b0, tgt_col_ff} + (CLW+1)'(1);
      wrap     = is_nl || (col_inc == (CLW+1)'(COLUMNS));
      last_row = (tgt_row_ff == RW'(ROWS - 1));
      overflow = wrap && last_row;
      attr_eff = (attr_ff == 8'd0) ? def_attr_ff : attr_ff;
      put_we   = ctl_cmd.exec && put_ok && !is_nl;

      dp_status.sweep_req  = (put_ok && overflow) || (cmd_ff == CMD_CLEAR);
      dp_status.sweep_last = (scan_ff == AW'(CELLS - 1));

      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      scrolled_in = scrolled_ff;
      if (ctl_cmd.exec) begin
         scrolled_in = put_ok && overflow;
         if (put_ok) begin
            // an overflow stays on the bottom row after the scroll
            cur_col_in = wrap ? '0 : col_inc[CLW-1:0];
            cur_row_in = (wrap && !last_row) ? tgt_row_ff + RW'(1) : tgt_row_ff;
         end else if (cmd_ff == CMD_CLEAR) begin
            cur_col_in = '0;
            cur_row_in = '0;
         end
      end
   end

   // Sweep: one cell per cycle, write lands in the cycle after the read
   always_comb begin
      scan_in = scan_ff;
      mode_in = mode_ff;
      if (ctl_cmd.exec && dp_status.sweep_req) begin
         scan_in = '0;
         mode_in = (cmd_ff == CMD_CLEAR) ? MODE_BLANK : MODE_SCROLL;
      end else if (ctl_cmd.sweep_step) begin
         scan_in = scan_ff + AW'(1);
      end

      copy_now = ctl_cmd.sweep_step && (mode_ff == MODE_SCROLL) &&
                 (32'(scan_ff) < BASE);
      if (copy_now) wr_src_in = SRC_COPY;
      else if (mode_ff == MODE_BLANK) wr_src_in = SRC_BLANK;
      else wr_src_in = SRC_ZERO;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         mode_ff    <= MODE_ZERO;
         wr_pend_ff <= 1'b0;
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         def_attr_ff <= ATTR_RESET;
      end else begin
         scan_ff    <= scan_in;
         mode_ff    <= mode_in;
         wr_pend_ff <= ctl_cmd.sweep_step;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         if (csr_wr_en) def_attr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= scan_ff;
      wr_src_ff   <= wr_src_in;
      scrolled_ff <= scrolled_in;
   end

   // Memory port mux: pending sweep write or a put
   always_comb begin
      mem_we    = wr_pend_ff || put_we;
      mem_waddr = wr_pend_ff ? wr_addr_ff : addr_ff;
      mem_wdata = {attr_eff, ch_ff};
      if (wr_pend_ff) begin
         unique case (wr_src_ff)
            SRC_COPY:  mem_wdata = rd_data_ff;
            SRC_BLANK: mem_wdata = {def_attr_ff, SPACE_CODE};
            default:   mem_wdata = 16'd0;
         endcase
      end
      rd_addr = copy_now ? AW'(32'(scan_ff) + COLUMNS) : addr_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[rd_addr];
   end

   // Response register
   always_ff @(posedge clock) begin
      if (ctl_cmd.finish) begin
         out_cursor_ff   <= CURSOR_W'(32'(cur_row_ff) * COLUMNS + 32'(cur_col_ff));
         out_scrolled_ff <= scrolled_ff;
         out_err_ff      <= err_ff;
         if ((cmd_ff == CMD_READ) && !err_ff) begin
            out_char_ff <= rd_data_ff[7:0];
            out_attr_ff <= rd_data_ff[15:8];
         end else begin
            out_char_ff <= 8'd0;
            out_attr_ff <= 8'd0;
         end
      end
   end

   assign rsp_tdata = {3'b000, out_err_ff, out_attr_ff, out_char_ff,
                       out_scrolled_ff, out_cursor_ff};

endmodule

// ===== rtl/core/text_console_writer.sv =====
// Text console of ROWS x COLUMNS character cells with a cursor. Each request
// transaction carries a command in req_tuser: put a character (at the cursor or
// at a given row and column), clear the screen, or read one cell; every request
// yields exactly one response transaction with the cursor cell index after the
// command, a scroll flag, the read cell and an error flag for a position off the
// grid. A put, read or ignored command steps through accept, decode, execute
// and finish: the response register loads in the finish step and the next
// request can be taken after that step. A clear, and a put on the bottom row
// that wraps or takes a newline and so scrolls, add one pass over the cell
// memory, one cell per cycle. After reset a clearing pass zeroes the memory
// with req_tready low; csr writes of the default attribute are taken at any
// time but belong between commands. A finished response waits in its own
// register while the next request is accepted; that next command then stalls in
// its finish step until the waiting response transaction is taken.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   // tuser: command[1:0], use_position[2]
   input  logic [tcw_pkg::REQ_USER_W-1:0]  req_tuser,
   // tdata: char_code[7:0], row_index[12:8], col_index[19:13], attribute[27:20]
   input  logic [tcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: cursor_cell[10:0], scrolled[11], read_char[19:12], read_attr[27:20],
   //        error[28]
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic [7:0]                      csr_wr_data
);
   import tcw_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl_cmd    (ctl_cmd),
      .dp_status  (dp_status)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl_cmd     (ctl_cmd),
      .dp_status   (dp_status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== rtl/core/tcw_props.sv =====
module tcw_props (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);
   import tcw_pkg::*;

   // Stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // Stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response payload changed while stalled");

   // Clearing pass after reset blocks requests
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during clearing pass");

   // One command at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

   // Rejected position neither scrolls nor returns cell contents
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[28] |-> !rsp_tdata[11] && (rsp_tdata[27:12] == 16'd0))
      else $error("error response carries scroll or cell data");

endmodule

bind text_console_writer tcw_props u_tcw_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
